// ===== hw/rtl/scd_pkg.sv =====
// Shared types and constants for the SLIP command frame decoder.
// No dependencies; imported by every module of the block.
package scd_pkg;

   // SLIP framing bytes
   localparam logic [7:0] FRAME_END     = 8'hC0;
   localparam logic [7:0] FRAME_ESC     = 8'hDB;
   localparam logic [7:0] FRAME_ESC_END = 8'hDC;
   localparam logic [7:0] FRAME_ESC_ESC = 8'hDD;

   // Item modes
   localparam logic MODE_BYTE  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_CMD_A = 2'd0;
   localparam logic [1:0] REG_CMD_B = 2'd1;
   localparam logic [1:0] REG_CMD_C = 2'd2;

   // Register reset values
   localparam logic [7:0] CMD_A_RESET = 8'd0;
   localparam logic [7:0] CMD_B_RESET = 8'd1;
   localparam logic [7:0] CMD_C_RESET = 8'd2;

   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_CMD     = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] cmd_a;
      logic [7:0] cmd_b;
      logic [7:0] cmd_c;
   } cmd_set_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] cmd;
   } result_type;

endpackage

// ===== hw/rtl/scd_csr.sv =====
// Command code registers of the SLIP command frame decoder.
// Depends on scd_pkg.
module scd_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output scd_pkg::cmd_set_type cmds
);
   import scd_pkg::*;

   logic [7:0] cmd_a_ff;
   logic [7:0] cmd_b_ff;
   logic [7:0] cmd_c_ff;
   logic       wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   // index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_a_ff <= CMD_A_RESET;
         cmd_b_ff <= CMD_B_RESET;
         cmd_c_ff <= CMD_C_RESET;
      end else if (wr_en) begin
         case (csr_index)
            REG_CMD_A: cmd_a_ff <= csr_wdata;
            REG_CMD_B: cmd_b_ff <= csr_wdata;
            REG_CMD_C: cmd_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cmds.cmd_a = cmd_a_ff;
   assign cmds.cmd_b = cmd_b_ff;
   assign cmds.cmd_c = cmd_c_ff;

endmodule

// ===== hw/rtl/scd_parser.sv =====
// Frame parser: phase machine, escape flag and command latch of the decoder.
// Depends on scd_pkg.
module scd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 mode,
   input  logic [7:0]           in_byte,
   input  scd_pkg::cmd_set_type cmds,
   output scd_pkg::result_type  res
);
   import scd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic [7:0] cmd_ff, cmd_in;
   logic       cmd_hit;
   logic [7:0] unesc_byte;

   assign cmd_hit = (in_byte == cmds.cmd_a) || (in_byte == cmds.cmd_b)
                 || (in_byte == cmds.cmd_c);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (mode == MODE_FLUSH) begin
         phase_in = PH_WAIT;
      end else begin
         case (phase_ff)
            PH_CMD: begin
               if (in_byte == FRAME_END) phase_in = PH_CMD;
               else if (cmd_hit)         phase_in = PH_PAYLOAD;
               else                      phase_in = PH_WAIT;
            end
            PH_PAYLOAD: begin
               if (in_byte == FRAME_END) phase_in = PH_WAIT;
            end
            default: begin
               if (in_byte == FRAME_END) phase_in = PH_CMD;
               else                      phase_in = PH_WAIT;
            end
         endcase
      end
   end

   always_comb begin
      unesc_byte = in_byte;
      if (esc_ff) begin
         if (in_byte == FRAME_ESC_END)      unesc_byte = FRAME_END;
         else if (in_byte == FRAME_ESC_ESC) unesc_byte = FRAME_ESC;
      end
   end

   // results, escape flag and command latch
   always_comb begin
      esc_in    = esc_ff;
      cmd_in    = cmd_ff;
      res.valid = 1'b0;
      res.kind  = KIND_BYTE;
      res.data  = 8'd0;
      res.cmd   = cmd_ff;
      if (mode == MODE_FLUSH) begin
         esc_in = 1'b0;
         if (phase_ff == PH_PAYLOAD) begin
            res.valid = 1'b1;
            res.kind  = KIND_ABORT;
         end
      end else begin
         case (phase_ff)
            PH_CMD: begin
               if (in_byte != FRAME_END && cmd_hit) cmd_in = in_byte;
            end
            PH_PAYLOAD: begin
               if (in_byte == FRAME_END) begin
                  // escape flag survives the frame end
                  res.valid = 1'b1;
                  res.kind  = KIND_DONE;
               end else if (in_byte == FRAME_ESC) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in    = 1'b0;
                  res.valid = 1'b1;
                  res.kind  = KIND_BYTE;
                  res.data  = unesc_byte;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         esc_ff   <= 1'b0;
         cmd_ff   <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         cmd_ff   <= cmd_in;
      end
   end

`ifndef SYNTHESIS
   a_byte_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind == KIND_BYTE |-> phase_ff == PH_PAYLOAD)
      else $error("payload byte produced outside payload phase");
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      step && mode == MODE_FLUSH |=> phase_ff == PH_WAIT && !esc_ff)
      else $error("flush did not clear the parser");
   a_payload_cmd_valid: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_CMD && phase_in == PH_PAYLOAD |=>
      cmd_ff == $past(in_byte))
      else $error("command not latched on entry to payload");
`endif

endmodule

// ===== hw/rtl/slip_command_frame_decoder.sv =====
// SLIP command frame decoder, top level: input register, parser, result register.
// Depends on scd_pkg, scd_csr and scd_parser.
// A transaction taken into the input register is stepped through the parser into the
// result register and taken on rsp_. Throughput: one req_ transaction per cycle unless stalled.
// Input stalls only while a result waits unaccepted in the output register.
// Reset (sync, active high): parser waiting for begin, flags clear, codes 0/1/2, both empty.
module slip_command_frame_decoder (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_frame_cmd,
   // configuration channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import scd_pkg::*;

   cmd_set_type cmds;
   result_type  res;

   // input register
   logic       in_valid_ff;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff;
   logic [7:0] out_byte_ff;
   logic [7:0] out_cmd_ff;

   logic       advance;
   logic       step;
   logic       load_in;

   // The held transaction moves on whenever the result slot is empty or
   // being drained this cycle; items that make no result move on too.
   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign load_in   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload of the input register needs no reset
   always_ff @(posedge clock) begin
      if (load_in) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_in_byte;
      end
   end

   scd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmds      (cmds)
   );

   scd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .mode    (in_mode_ff),
      .in_byte (in_byte_ff),
      .cmds    (cmds),
      .res     (res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = step && res.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         out_kind_ff <= res.kind;
         out_byte_ff <= res.data;
         out_cmd_ff  <= res.cmd;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_kind  = out_kind_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_cmd = out_cmd_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with room downstream");
   a_held_while_blocked: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff)
      else $error("held transaction lost while result stalled");
   a_byte_zero_on_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_BYTE |-> rsp_out_byte == 8'd0)
      else $error("frame mark carries a data byte");
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_kind == KIND_BYTE || rsp_out_kind == KIND_DONE
                    || rsp_out_kind == KIND_ABORT)
      else $error("illegal result kind");
`endif

endmodule

// ===== tb/sv/slip_command_frame_decoder_checker.sv =====
// Scoreboard for the SLIP command frame decoder: mirrors the deframer state from
// the observed req_ and csr_ transactions and checks every rsp_ transaction in order.
// Depends on scd_pkg.
module slip_command_frame_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_out_kind,
   input  logic [7:0] rsp_out_byte,
   input  logic [7:0] rsp_frame_cmd,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         bytes_seen,
   output int         frames_seen,
   output int         aborts_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import scd_pkg::*;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] cmd;
   } decoded_event_type;

   // mirrored decoder state
   phase_type   phase;
   logic        esc_held;
   logic [7:0]  frame_cmd;
   cmd_set_type codes;

   decoded_event_type decoded_due[$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      bytes_seen  = 0;
      frames_seen = 0;
      aborts_seen = 0;
   end

   // one parser step; returns 1 when the transaction yields a result
   function automatic logic deframe_step(input logic mode, input logic [7:0] b,
                                         output decoded_event_type ev);
      logic emit;
      emit = 1'b0;
      ev   = '0;
      if (mode == MODE_FLUSH) begin
         emit     = (phase == PH_PAYLOAD);
         ev.kind  = KIND_ABORT;
         phase    = PH_WAIT;
         esc_held = 1'b0;
      end else begin
         case (phase)
            PH_CMD: begin
               if (b != FRAME_END) begin
                  if (b == codes.cmd_a || b == codes.cmd_b || b == codes.cmd_c) begin
                     frame_cmd = b;
                     phase     = PH_PAYLOAD;
                  end else begin
                     phase = PH_WAIT;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (b == FRAME_END) begin
                  phase   = PH_WAIT;
                  ev.kind = KIND_DONE;
                  emit    = 1'b1;
               end else if (b == FRAME_ESC) begin
                  esc_held = 1'b1;
               end else begin
                  ev.data = b;
                  if (esc_held) begin
                     if (b == FRAME_ESC_END)      ev.data = FRAME_END;
                     else if (b == FRAME_ESC_ESC) ev.data = FRAME_ESC;
                     esc_held = 1'b0;
                  end
                  ev.kind = KIND_BYTE;
                  emit    = 1'b1;
               end
            end
            default: phase = (b == FRAME_END) ? PH_CMD : PH_WAIT;
         endcase
      end
      ev.cmd = frame_cmd;
      return emit;
   endfunction

   always @(posedge clock) begin
      decoded_event_type ev;
      decoded_event_type want;
      if (reset) begin
         phase     = PH_WAIT;
         esc_held  = 1'b0;
         frame_cmd = 8'h00;
         codes     = '{cmd_a: CMD_A_RESET, cmd_b: CMD_B_RESET, cmd_c: CMD_C_RESET};
         decoded_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CMD_A: codes.cmd_a = csr_wdata;
               REG_CMD_B: codes.cmd_b = csr_wdata;
               REG_CMD_C: codes.cmd_c = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (deframe_step(req_mode, req_in_byte, ev))
               decoded_due.insert(decoded_due.size(), ev);
         end
         if (rsp_valid && rsp_ready) begin
            case (rsp_out_kind)
               KIND_BYTE:  bytes_seen++;
               KIND_DONE:  frames_seen++;
               KIND_ABORT: aborts_seen++;
               default: ;
            endcase
            if (decoded_due.size() == 0) begin
               $display("%0t: unexpected result kind %0d byte %02h cmd %02h", $time,
                        rsp_out_kind, rsp_out_byte, rsp_frame_cmd);
               fail_count++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_out_kind !== want.kind) begin
                  $display("%0t: kind mismatch, expected %0d got %0d", $time,
                           want.kind, rsp_out_kind);
                  fail_count++;
               end
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: byte mismatch, expected %02h got %02h", $time,
                           want.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_frame_cmd !== want.cmd) begin
                  $display("%0t: command mismatch, expected %02h got %02h", $time,
                           want.cmd, rsp_frame_cmd);
                  fail_count++;
               end
            end
         end
      end
      pending = decoded_due.size();
   end

endmodule

// ===== tb/sv/slip_command_frame_decoder_test.sv =====
// Top of the SLIP command frame decoder testbench: clock, reset, stimulus and verdict.
// Depends on scd_pkg, slip_command_frame_decoder and slip_command_frame_decoder_checker.
module slip_command_frame_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;  // long back-pressure stretch on rsp_
   localparam int SETTLE_CYCLES = 6;    // covers the input and result registers with margin
   localparam int PHASE_ITEMS   = 165;

   // receiver stall patterns
   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_frame_cmd;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   int fail_count;
   int pending;
   int bytes_seen;
   int frames_seen;
   int aborts_seen;

   int unsigned cycle_count   = 0;
   int          items_sent    = 0;
   int          burst_left    = 0;
   int          cmd_sets      = 1;
   int          hold_requests = 0;    // raised by the stimulus, served by the receiver
   logic [7:0]  code_a, code_b, code_c;   // command codes currently programmed

   slip_command_frame_decoder u_top (.*);

   slip_command_frame_decoder_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Hard stop in case the block hangs a handshake
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Result side: ready follows a pattern that is picked anew at random after each span,
   // including long spells of always-ready. A hold-off request from the stimulus
   // forces ready low for a long, fixed stretch so the pipeline backs up.
   initial begin : receiver
      rx_style_type style;
      int           span;
      int           holds_served;
      holds_served = 0;
      rsp_ready    = 1'b0;
      forever begin
         style = rx_style_type'($urandom_range(0, 3));
         span  = $urandom_range(20, 120);
         repeat (span) begin
            @(negedge clock);
            if (hold_requests != holds_served) begin
               rsp_ready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               holds_served++;
            end
            case (style)
               RX_ALWAYS: rsp_ready = 1'b1;
               RX_COIN:   rsp_ready = 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready = ($urandom_range(0, 3) == 0);
               default:   rsp_ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offer one transaction on req_. Called at a falling edge, returns at a falling
   // edge with valid still high, so back-to-back transactions never drop valid.
   // Between bursts valid may go low for a random gap.
   task automatic put_item(input logic mode, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_valid   = 1'b1;
      req_mode    = mode;
      req_in_byte = b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Stop sending and wait for every outstanding result, then let any
   // result-free transactions still in the pipe settle.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_cmd_set(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c);
      write_reg(REG_CMD_A, a);
      write_reg(REG_CMD_B, b);
      write_reg(REG_CMD_C, c);
      code_a = a;
      code_b = b;
      code_c = c;
      cmd_sets++;
   endtask

   // Mostly well-formed frames with random commands, escapes and lengths;
   // the rest is line noise, stray flushes and frames cut short.
   task automatic run_random_phase(input int n_items);
      int         stop_at;
      int         len;
      int         pick;
      logic [7:0] cmd;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 8) begin
            if ($urandom_range(0, 3) == 0) put_item(MODE_FLUSH, 8'($urandom));
            else put_item(MODE_BYTE, 8'($urandom));
         end else begin
            put_item(MODE_BYTE, FRAME_END);
            if ($urandom_range(0, 9) == 0) put_item(MODE_BYTE, FRAME_END);
            pick = $urandom_range(0, 19);
            if (pick < 6)       cmd = code_a;
            else if (pick < 12) cmd = code_b;
            else if (pick < 17) cmd = code_c;
            else                cmd = 8'($urandom);
            put_item(MODE_BYTE, cmd);
            // mostly short payloads, now and then a long one
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            repeat (len) begin
               case ($urandom_range(0, 9))
                  0: begin
                     put_item(MODE_BYTE, FRAME_ESC);
                     put_item(MODE_BYTE, FRAME_ESC_END);
                  end
                  1: begin
                     put_item(MODE_BYTE, FRAME_ESC);
                     put_item(MODE_BYTE, FRAME_ESC_ESC);
                  end
                  2: begin
                     put_item(MODE_BYTE, FRAME_ESC);
                     put_item(MODE_BYTE, 8'($urandom));
                  end
                  3: put_item(MODE_BYTE, FRAME_ESC);
                  default: put_item(MODE_BYTE, 8'($urandom));
               endcase
            end
            pick = $urandom_range(0, 19);
            if (pick < 16)      put_item(MODE_BYTE, FRAME_END);
            else if (pick < 19) put_item(MODE_FLUSH, 8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      // Opening sequence under the reset command codes (0, 1, 2):
      // noise while waiting, doubled END, escapes of every flavour, ESC ESC,
      // END while an escape is pending (carried into the next frame),
      // flush mid-payload, invalid command, flush outside a payload.
      static logic [8:0] opening_seq[$] = '{
         {MODE_BYTE, 8'h55}, {MODE_BYTE, FRAME_END}, {MODE_BYTE, FRAME_END},
         {MODE_BYTE, 8'h01}, {MODE_BYTE, 8'h00}, {MODE_BYTE, 8'hFF},
         {MODE_BYTE, FRAME_ESC}, {MODE_BYTE, FRAME_ESC_END},
         {MODE_BYTE, FRAME_ESC}, {MODE_BYTE, FRAME_ESC_ESC},
         {MODE_BYTE, FRAME_ESC}, {MODE_BYTE, 8'h41},
         {MODE_BYTE, FRAME_ESC}, {MODE_BYTE, FRAME_ESC}, {MODE_BYTE, 8'h7E},
         {MODE_BYTE, FRAME_ESC}, {MODE_BYTE, FRAME_END},
         {MODE_BYTE, FRAME_END}, {MODE_BYTE, 8'h02}, {MODE_BYTE, FRAME_ESC_END},
         {MODE_FLUSH, 8'hA5},
         {MODE_BYTE, FRAME_END}, {MODE_BYTE, 8'h99}, {MODE_BYTE, 8'h33},
         {MODE_BYTE, FRAME_END}, {MODE_FLUSH, 8'h5A}, {MODE_FLUSH, 8'h00}
      };

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = MODE_BYTE;
      req_in_byte = 8'h00;
      csr_valid   = 1'b0;
      csr_index   = REG_CMD_A;
      csr_wdata   = 8'h00;
      code_a      = CMD_A_RESET;
      code_b      = CMD_B_RESET;
      code_c      = CMD_C_RESET;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (opening_seq[i]) put_item(opening_seq[i][8], opening_seq[i][7:0]);

      // extreme codes; during this phase the receiver backs off for a long
      // stretch while the sender keeps offering, so req_ready must drop
      drain_results();
      write_cmd_set(8'h00, 8'hFF, 8'h80);
      hold_requests++;
      run_random_phase(PHASE_ITEMS);

      // framing bytes as codes; END can never be taken as a command
      drain_results();
      write_cmd_set(FRAME_END, FRAME_ESC, FRAME_ESC_ESC);
      run_random_phase(PHASE_ITEMS);

      // all three registers the same
      drain_results();
      write_cmd_set(8'hFF, 8'hFF, 8'hFF);
      run_random_phase(PHASE_ITEMS);

      drain_results();
      write_cmd_set(8'h7F, 8'h01, 8'hFE);
      run_random_phase(PHASE_ITEMS);

      drain_results();
      write_cmd_set(8'($urandom), 8'($urandom), 8'($urandom));
      run_random_phase(PHASE_ITEMS);

      drain_results();
      repeat (10) @(negedge clock);

      $display("Sent %0d transactions under %0d command sets, one %0d-cycle hold-off.",
               items_sent, cmd_sets, HOLD_CYCLES);
      $display("Checked %0d payload bytes, %0d completed frames, %0d aborted frames.",
               bytes_seen, frames_seen, aborts_seen);
      if (pending != 0)
         $display("%0t: %0d expected results never arrived", $time, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/scd_pkg.sv
hw/rtl/scd_csr.sv
hw/rtl/scd_parser.sv
hw/rtl/slip_command_frame_decoder.sv
tb/sv/slip_command_frame_decoder_checker.sv
tb/sv/slip_command_frame_decoder_test.sv
